// ===== src/lss_pkg.sv =====
// Shared types, constants and codes for the searchable LIFO stack.
`default_nettype none
package lss_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 32;
  localparam int MODE_W = 3;
  localparam int STAT_W = 2;
  localparam int POS_W  = 6;
  localparam int OCC_W  = 7;

  localparam logic [MODE_W-1:0] MODE_PUSH     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TRAVERSE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SEARCH   = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

  localparam logic signed [DATA_W-1:0] DATA_UNDERFLOW = -32'sd1;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] operand;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
    logic [OCC_W-1:0]         occupancy;
    logic                     last;
  } out_word_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic                     srch;
    logic signed [DATA_W-1:0] value;
  } chain_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SRCH,
    ST_TRAV
  } state_t;

endpackage
`default_nettype wire

// ===== src/lss_cell.sv =====
// One stack cell: a data word that shifts with its neighbors and compares itself to a key.
`default_nettype none
module lss_cell (
  input  wire                                   clk,
  input  wire lss_pkg::chain_ctl_t              ctl,
  input  wire logic signed [lss_pkg::DATA_W-1:0] up_data,
  input  wire logic signed [lss_pkg::DATA_W-1:0] dn_data,
  input  wire logic signed [lss_pkg::DATA_W-1:0] top_data,
  input  wire logic                             at_bottom,
  input  wire logic                             in_use,
  output logic signed [lss_pkg::DATA_W-1:0]     data,
  output logic                                  hit
);
  import lss_pkg::*;

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    case (ctl.op)
      CELL_PUSH: data_nxt = up_data;
      CELL_POP:  data_nxt = dn_data;
      // During a traverse the bottom occupied cell wraps the top word around.
      CELL_ROT:  data_nxt = at_bottom ? top_data : dn_data;
      default:   data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign hit  = in_use && (data_r == ctl.value);

endmodule
`default_nettype wire

// ===== src/lss_chain.sv =====
// Row of stack cells, top at index zero, with the registered search hit vector and its encoder.
`default_nettype none
module lss_chain (
  input  wire                                clk,
  input  wire lss_pkg::chain_ctl_t           ctl,
  input  wire logic [lss_pkg::OCC_W-1:0]     cnt,
  output logic signed [lss_pkg::DATA_W-1:0]  top_data,
  output logic                               hit_any,
  output logic [lss_pkg::IDX_W-1:0]          hit_pos
);
  import lss_pkg::*;

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]         cell_hit;
  logic [DEPTH-1:0]         match_r;
  logic [DEPTH-1:0]         match_nxt;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] up_d;
    logic signed [DATA_W-1:0] dn_d;

    if (i == 0) begin : g_top
      assign up_d = ctl.value;
    end else begin : g_mid_up
      assign up_d = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign dn_d = cell_data[i];
    end else begin : g_mid_dn
      assign dn_d = cell_data[i+1];
    end

    lss_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .up_data   (up_d),
      .dn_data   (dn_d),
      .top_data  (cell_data[0]),
      .at_bottom (cnt == OCC_W'(i + 1)),
      .in_use    (cnt > OCC_W'(i)),
      .data      (cell_data[i]),
      .hit       (cell_hit[i])
    );
  end

  assign match_nxt = ctl.srch ? cell_hit : match_r;

  always_ff @(posedge clk) begin
    match_r <= match_nxt;
  end

  // The lowest set bit is the match nearest the top.
  always_comb begin
    hit_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_pos = IDX_W'(i);
      end
    end
  end

  assign hit_any  = |match_r;
  assign top_data = cell_data[0];

endmodule
`default_nettype wire

// ===== src/searchable_lifo_stack_unit.sv =====
// Top level of the searchable LIFO stack: operation sequencer, fill count and output register.
// The stack is a row of cells with the top word in the first cell; push and pop shift the
// whole row at once. Push, pop and peek form their result in the accepting cycle, as do
// search and traverse of an empty stack. Search of a nonempty stack has two steps: every
// cell compares against the key in the accepting cycle, and the registered hit vector is
// priority encoded in the ST_SRCH state. Traverse of n entries begins with the accepting
// cycle, then gives one word per cycle while the output register is free, emitted by
// rotating the occupied cells up one place per word, so the stack is back in its original
// order when the last word goes out. A new operation is taken only when the sequencer is
// idle and the output register is empty or being drained; each operation gives one
// registered result word (traverse one per entry), and unused mode codes give none.
`default_nettype none
module searchable_lifo_stack_unit (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire lss_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire                     out_ready,
  output lss_pkg::out_word_t      out_word
);
  import lss_pkg::*;

  state_t              state_r, state_nxt;
  logic [OCC_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_r, out_nxt;

  chain_ctl_t               ctl;
  logic signed [DATA_W-1:0] top_data;
  logic                     hit_any;
  logic [IDX_W-1:0]         hit_pos;

  logic      out_free;
  logic      accept;
  logic      load;
  logic      trav_end;
  out_word_t res;

  lss_chain u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .cnt      (cnt_r),
    .top_data (top_data),
    .hit_any  (hit_any),
    .hit_pos  (hit_pos)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign trav_end = (OCC_W'(pos_r) + OCC_W'(1)) == cnt_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    ctl.op        = CELL_HOLD;
    ctl.srch      = 1'b0;
    ctl.value     = in_word.operand;
    load          = 1'b0;
    res.status    = STAT_OK;
    res.data      = '0;
    res.position  = '0;
    res.occupancy = cnt_r;
    res.last      = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_word.mode)
            MODE_PUSH: begin
              load = 1'b1;
              if (cnt_r == OCC_W'(DEPTH)) begin
                res.status = STAT_OVERFLOW;
              end else begin
                ctl.op        = CELL_PUSH;
                cnt_nxt       = cnt_r + OCC_W'(1);
                res.occupancy = cnt_nxt;
              end
            end
            MODE_POP: begin
              load = 1'b1;
              if (cnt_r == '0) begin
                res.status = STAT_EMPTY;
                res.data   = DATA_UNDERFLOW;
              end else begin
                ctl.op        = CELL_POP;
                cnt_nxt       = cnt_r - OCC_W'(1);
                res.data      = top_data;
                res.occupancy = cnt_nxt;
              end
            end
            MODE_PEEK: begin
              load = 1'b1;
              if (cnt_r == '0) begin
                res.status = STAT_EMPTY;
              end else begin
                res.data = top_data;
              end
            end
            MODE_TRAVERSE: begin
              if (cnt_r == '0) begin
                load       = 1'b1;
                res.status = STAT_EMPTY;
              end else begin
                pos_nxt   = '0;
                state_nxt = ST_TRAV;
              end
            end
            MODE_SEARCH: begin
              if (cnt_r == '0) begin
                load       = 1'b1;
                res.status = STAT_EMPTY;
              end else begin
                ctl.srch  = 1'b1;
                state_nxt = ST_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SRCH: begin
        if (out_free) begin
          load = 1'b1;
          if (hit_any) begin
            res.position = POS_W'(hit_pos);
          end else begin
            res.status = STAT_NOT_FOUND;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_TRAV: begin
        if (out_free) begin
          load         = 1'b1;
          ctl.op       = CELL_ROT;
          res.data     = top_data;
          res.position = POS_W'(pos_r);
          res.last     = trav_end;
          if (trav_end) begin
            pos_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt = pos_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_nxt = load ? res : out_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule
`default_nettype wire
